// ===== hdl/imsu_pkg.sv =====
// Shared types and constants for the Ising Metropolis site updater.
// Used by the register block, the controller, the datapath and the top level.
package imsu_pkg;

  // Default lattice capacity per side
  localparam int IMSU_MAX_SIDE = 128;

  // Configuration port geometry
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  // Field widths
  localparam int SIDE_CFG_W = 8;
  localparam int THR_W      = 16;
  localparam int UNI_W      = 16;
  localparam int SUM_W      = 16;
  localparam int SQ_W       = 29;

  // Register reset values
  localparam logic [SIDE_CFG_W-1:0] SIDE_RESET = 8'd16;
  localparam logic [THR_W-1:0]      ACC4_RESET = 16'd8869;
  localparam logic [THR_W-1:0]      ACC8_RESET = 16'd1200;

  // Saturation bound of the running spin sum
  localparam logic signed [SUM_W:0] SUM_LIMIT = 17'sd16384;

  // Register indexes
  typedef enum logic [1:0] {
    REG_SIDE = 2'd0,
    REG_ACC4 = 2'd1,
    REG_ACC8 = 2'd2
  } reg_idx_t;

  // Item commands; the unused code behaves as a measure
  typedef enum logic [1:0] {
    CMD_LOAD    = 2'd0,
    CMD_UPDATE  = 2'd1,
    CMD_MEASURE = 2'd2
  } cmd_t;

  // Lattice read address choice
  typedef enum logic [2:0] {
    SEL_SELF,
    SEL_RIGHT,
    SEL_DOWN,
    SEL_LEFT,
    SEL_UP
  } nbr_sel_t;

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_RD_SELF,
    ST_RD_RIGHT,
    ST_RD_DOWN,
    ST_RD_LEFT,
    ST_RD_UP,
    ST_DECIDE,
    ST_EMIT
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    nbr_sel_t rd_sel;
    logic     take_item;
    logic     cap_self;
    logic     cap_nbr;
    logic     do_load;
    logic     do_update;
    logic     emit;
  } dp_cmd_t;

  // Acceptance thresholds from the register block
  typedef struct packed {
    logic [THR_W-1:0] accept_four;
    logic [THR_W-1:0] accept_eight;
  } thr_t;

endpackage

// ===== hdl/imsu_regs.sv =====
// Configuration registers behind the APB-style port, with side clamping.
// Depends on imsu_pkg.
module imsu_regs #(
  parameter int MAX_SIDE = imsu_pkg::IMSU_MAX_SIDE,
  parameter int SIDE_W   = $clog2(MAX_SIDE + 1)
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [imsu_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [imsu_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [imsu_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                             pready,
  output logic [SIDE_W-1:0]                side_eff,
  output logic                             side_wr,
  output imsu_pkg::thr_t                   thr
);
  import imsu_pkg::*;

  logic [SIDE_CFG_W-1:0] side_r;
  logic [THR_W-1:0]      acc4_r;
  logic [THR_W-1:0]      acc8_r;
  logic                  wr_en;
  logic [1:0]            idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = paddr[3:2];

  // Write registers on the access beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r <= SIDE_RESET;
      acc4_r <= ACC4_RESET;
      acc8_r <= ACC8_RESET;
    end else if (wr_en) begin
      unique case (idx)
        REG_SIDE: side_r <= pwdata[SIDE_CFG_W-1:0];
        REG_ACC4: acc4_r <= pwdata[THR_W-1:0];
        REG_ACC8: acc8_r <= pwdata[THR_W-1:0];
        default:  ;
      endcase
    end
  end

  assign side_wr = wr_en && (idx == REG_SIDE);

  // Read back the stored values
  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_SIDE: prdata = CFG_DATA_W'(side_r);
      REG_ACC4: prdata = CFG_DATA_W'(acc4_r);
      REG_ACC8: prdata = CFG_DATA_W'(acc8_r);
      default:  prdata = '0;
    endcase
  end

  // Clamp the side into the supported range
  always_comb begin
    if (int'(side_r) < 2) begin
      side_eff = SIDE_W'(2);
    end else if (int'(side_r) > MAX_SIDE) begin
      side_eff = SIDE_W'(MAX_SIDE);
    end else begin
      side_eff = SIDE_W'(side_r);
    end
  end

  assign thr.accept_four  = acc4_r;
  assign thr.accept_eight = acc8_r;

endmodule

// ===== hdl/imsu_ctrl.sv =====
// Sequencer for load, update and measure items: issues lattice reads one per cycle.
// Depends on imsu_pkg; drives the datapath through a dp_cmd_t bundle.
module imsu_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [1:0]        in_cmd,
  output logic              busy,
  output imsu_pkg::dp_cmd_t cmd
);
  import imsu_pkg::*;

  state_t state_r;
  state_t state_nxt;

  // Hold the state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

  // Advance through the read sequence and raise datapath commands
  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    cmd.rd_sel = SEL_SELF;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.take_item = 1'b1;
          unique case (in_cmd)
            CMD_LOAD:   state_nxt = ST_LOAD;
            CMD_UPDATE: state_nxt = ST_RD_SELF;
            default:    state_nxt = ST_EMIT;
          endcase
        end
      end
      ST_LOAD: begin
        cmd.do_load = 1'b1;
        state_nxt   = ST_EMIT;
      end
      ST_RD_SELF: begin
        cmd.rd_sel = SEL_SELF;
        state_nxt  = ST_RD_RIGHT;
      end
      ST_RD_RIGHT: begin
        cmd.rd_sel   = SEL_RIGHT;
        cmd.cap_self = 1'b1;
        state_nxt    = ST_RD_DOWN;
      end
      ST_RD_DOWN: begin
        cmd.rd_sel  = SEL_DOWN;
        cmd.cap_nbr = 1'b1;
        state_nxt   = ST_RD_LEFT;
      end
      ST_RD_LEFT: begin
        cmd.rd_sel  = SEL_LEFT;
        cmd.cap_nbr = 1'b1;
        state_nxt   = ST_RD_UP;
      end
      ST_RD_UP: begin
        cmd.rd_sel  = SEL_UP;
        cmd.cap_nbr = 1'b1;
        state_nxt   = ST_DECIDE;
      end
      ST_DECIDE: begin
        cmd.do_update = 1'b1;
        state_nxt     = ST_EMIT;
      end
      ST_EMIT: begin
        cmd.emit  = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// ===== hdl/imsu_dp.sv =====
// Lattice memory, raster position, flip decision, spin sum and result registers.
// Depends on imsu_pkg; steered by the controller's dp_cmd_t bundle.
module imsu_dp #(
  parameter int MAX_SIDE = imsu_pkg::IMSU_MAX_SIDE,
  parameter int SIDE_W   = $clog2(MAX_SIDE + 1),
  parameter int COORD_W  = $clog2(MAX_SIDE),
  parameter int DEPTH    = MAX_SIDE * MAX_SIDE,
  parameter int ADDR_W   = $clog2(DEPTH)
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  imsu_pkg::dp_cmd_t                       cmd,
  input  logic [SIDE_W-1:0]                       side_eff,
  input  logic                                    side_wr,
  input  imsu_pkg::thr_t                          thr,
  input  logic                                    in_spin_in,
  input  logic [imsu_pkg::UNI_W-1:0]              in_uniform,
  output logic                                    out_valid,
  output logic                                    out_flipped,
  output logic                                    out_spin_out,
  output logic                                    out_last_site,
  output logic signed [imsu_pkg::SUM_W-1:0]       out_magnetization,
  output logic [imsu_pkg::SQ_W-1:0]               out_magnetization_squared
);
  import imsu_pkg::*;

  localparam int POS_W = ADDR_W + 1;

  // Lattice store, undefined until loaded
  logic mem [DEPTH];
  logic rd_q;

  logic [ADDR_W-1:0]       pos_r;
  logic [COORD_W-1:0]      x_r;
  logic [COORD_W-1:0]      y_r;
  logic signed [SUM_W-1:0] sum_r;
  logic                    spin_q_r;
  logic [UNI_W-1:0]        uni_r;
  logic                    self_r;
  logic [2:0]              cnt_r;
  logic                    flipped_r;
  logic                    spin_out_r;
  logic                    last_r;
  logic                    out_valid_r;

  logic [POS_W-1:0]        pos_w;
  logic [POS_W-1:0]        side_w;
  logic [POS_W-1:0]        total;
  logic [SIDE_W-1:0]       side_m1;
  logic                    x_at_end;
  logic                    y_at_end;
  logic                    last_pos;
  logic [POS_W-1:0]        nbr_addr;
  logic [ADDR_W-1:0]       rd_addr;
  logic [2:0]              cnt_all;
  logic [2:0]              aligned;
  logic                    flip;
  logic                    new_spin;
  logic signed [SUM_W:0]   delta;
  logic signed [SUM_W:0]   sum_add;
  logic signed [SUM_W-1:0] sum_nxt;
  logic [SUM_W-1:0]        sum_abs;
  logic [2*SUM_W-1:0]      sum_sq;

  // Position geometry
  assign pos_w    = POS_W'(pos_r);
  assign side_w   = POS_W'(side_eff);
  assign total    = side_w * side_w;
  assign side_m1  = side_eff - SIDE_W'(1);
  assign x_at_end = (SIDE_W'(x_r) == side_m1);
  assign y_at_end = (SIDE_W'(y_r) == side_m1);
  assign last_pos = (pos_w == total - POS_W'(1));

  // Pick the neighbour address with periodic wrap
  always_comb begin
    nbr_addr = pos_w;
    case (cmd.rd_sel)
      SEL_RIGHT: nbr_addr = x_at_end ? pos_w - side_w + POS_W'(1) : pos_w + POS_W'(1);
      SEL_LEFT:  nbr_addr = (x_r == '0) ? pos_w + side_w - POS_W'(1) : pos_w - POS_W'(1);
      SEL_DOWN:  nbr_addr = y_at_end ? POS_W'(x_r) : pos_w + side_w;
      SEL_UP:    nbr_addr = (y_r == '0) ? pos_w + total - side_w : pos_w - side_w;
      default:   nbr_addr = pos_w;
    endcase
  end
  assign rd_addr = nbr_addr[ADDR_W-1:0];

  // Metropolis decision: count neighbours aligned with the site
  assign cnt_all  = cnt_r + 3'(rd_q);
  assign aligned  = self_r ? cnt_all : 3'd4 - cnt_all;
  assign new_spin = ~self_r;
  always_comb begin
    if (aligned <= 3'd2) begin
      flip = 1'b1;
    end else if (aligned == 3'd3) begin
      flip = (uni_r < thr.accept_four);
    end else begin
      flip = (uni_r < thr.accept_eight);
    end
  end

  // Saturating update of the spin sum
  always_comb begin
    delta = '0;
    if (cmd.do_load) begin
      delta = spin_q_r ? 17'sd1 : -17'sd1;
    end else if (cmd.do_update && flip) begin
      delta = new_spin ? 17'sd2 : -17'sd2;
    end
    sum_add = (SUM_W + 1)'(sum_r) + delta;
    if (sum_add > SUM_LIMIT) begin
      sum_nxt = SUM_W'(SUM_LIMIT);
    end else if (sum_add < -SUM_LIMIT) begin
      sum_nxt = SUM_W'(-SUM_LIMIT);
    end else begin
      sum_nxt = sum_add[SUM_W-1:0];
    end
  end

  // Square of the sum for the result
  assign sum_abs = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);
  assign sum_sq  = sum_abs * sum_abs;

  // Lattice memory: one registered read and one write per cycle
  always_ff @(posedge clk) begin
    rd_q <= mem[rd_addr];
    if (cmd.do_load) begin
      mem[pos_r] <= spin_q_r;
    end else if (cmd.do_update && flip) begin
      mem[pos_r] <= new_spin;
    end
  end

  // Raster position and running sum
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      x_r   <= '0;
      y_r   <= '0;
      sum_r <= '0;
    end else if (side_wr) begin
      pos_r <= '0;
      x_r   <= '0;
      y_r   <= '0;
      sum_r <= '0;
    end else if (cmd.do_load || cmd.do_update) begin
      sum_r <= sum_nxt;
      if (last_pos) begin
        pos_r <= '0;
        x_r   <= '0;
        y_r   <= '0;
      end else begin
        pos_r <= pos_r + ADDR_W'(1);
        if (x_at_end) begin
          x_r <= '0;
          y_r <= y_r + COORD_W'(1);
        end else begin
          x_r <= x_r + COORD_W'(1);
        end
      end
    end
  end

  // Item capture, neighbour gathering and per-site result
  always_ff @(posedge clk) begin
    if (cmd.take_item) begin
      spin_q_r   <= in_spin_in;
      uni_r      <= in_uniform;
      cnt_r      <= '0;
      flipped_r  <= 1'b0;
      spin_out_r <= 1'b0;
      last_r     <= 1'b0;
    end
    if (cmd.cap_self) begin
      self_r <= rd_q;
    end
    if (cmd.cap_nbr) begin
      cnt_r <= cnt_all;
    end
    if (cmd.do_load) begin
      spin_out_r <= spin_q_r;
      last_r     <= last_pos;
    end
    if (cmd.do_update) begin
      flipped_r  <= flip;
      spin_out_r <= flip ? new_spin : self_r;
      last_r     <= last_pos;
    end
  end

  // Result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
    end
  end

  // Result payload, loaded with the beat
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_flipped               <= flipped_r;
      out_spin_out              <= spin_out_r;
      out_last_site             <= last_r;
      out_magnetization         <= sum_r;
      out_magnetization_squared <= sum_sq[SQ_W-1:0];
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== hdl/ising_metropolis_site_update.sv =====
// Top level of the Ising Metropolis site updater: registers, controller, datapath.
// Depends on imsu_pkg, imsu_regs, imsu_ctrl and imsu_dp.

// One item is taken while busy is low; its single result appears on the out_
// ports for one cycle under out_valid and must be captured then, as the block
// cannot be held off. A load passes the load and emit states and a measure
// the emit state alone; an update reads the site and its four neighbours in
// turn, since the lattice memory has one read port, before the decide and
// emit states; busy falls in the cycle the result shows, so the next item
// can follow at once. The lattice holds whatever was loaded: load every
// site of a sweep before updating. Writing side_length restarts the raster
// position and clears the magnetization.
module ising_metropolis_site_update #(
  parameter int MAX_SIDE = imsu_pkg::IMSU_MAX_SIDE
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        in_cmd,
  input  logic                              in_spin_in,
  input  logic [imsu_pkg::UNI_W-1:0]        in_uniform,
  output logic                              out_valid,
  output logic                              out_flipped,
  output logic                              out_spin_out,
  output logic                              out_last_site,
  output logic signed [imsu_pkg::SUM_W-1:0] out_magnetization,
  output logic [imsu_pkg::SQ_W-1:0]         out_magnetization_squared,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [imsu_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [imsu_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [imsu_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                              pready
);
  import imsu_pkg::*;

  localparam int SIDE_W = $clog2(MAX_SIDE + 1);

  logic [SIDE_W-1:0] side_eff;
  logic              side_wr;
  thr_t              thr;
  dp_cmd_t           cmd;

  // Configuration registers
  imsu_regs #(
    .MAX_SIDE (MAX_SIDE),
    .SIDE_W   (SIDE_W)
  ) u_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .side_eff (side_eff),
    .side_wr  (side_wr),
    .thr      (thr)
  );

  // Sequencer
  imsu_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .in_cmd (in_cmd),
    .busy   (busy),
    .cmd    (cmd)
  );

  // Lattice and arithmetic
  imsu_dp #(
    .MAX_SIDE (MAX_SIDE),
    .SIDE_W   (SIDE_W)
  ) u_dp (
    .clk                       (clk),
    .rst_n                     (rst_n),
    .cmd                       (cmd),
    .side_eff                  (side_eff),
    .side_wr                   (side_wr),
    .thr                       (thr),
    .in_spin_in                (in_spin_in),
    .in_uniform                (in_uniform),
    .out_valid                 (out_valid),
    .out_flipped               (out_flipped),
    .out_spin_out              (out_spin_out),
    .out_last_site             (out_last_site),
    .out_magnetization         (out_magnetization),
    .out_magnetization_squared (out_magnetization_squared)
  );

endmodule

// ===== hdl/imsu_checker.sv =====
// Port-level checks for the Ising Metropolis site updater, bound to the top level.
// Depends on imsu_pkg.
module imsu_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              start,
  input logic                              busy,
  input logic                              out_valid,
  input logic signed [imsu_pkg::SUM_W-1:0] out_magnetization,
  input logic [imsu_pkg::SQ_W-1:0]         out_magnetization_squared
);
  import imsu_pkg::*;

  logic signed [31:0] mag_ext;
  logic [31:0]        mag_sq;

  assign mag_ext = 32'(out_magnetization);
  assign mag_sq  = 32'(mag_ext * mag_ext);

  // An accepted item keeps the block busy in the next cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after an accepted item");

  // A result beat follows work in progress
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result beat without an item in progress");

  // One beat per item: never two strobes in a row
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for two cycles");

  // Magnetization stays inside its saturation bound
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_magnetization <= 16'sd16384) && (out_magnetization >= -16'sd16384))
    else $error("magnetization beyond its bound");

  // The square matches the sum on the same beat
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_magnetization_squared == mag_sq[SQ_W-1:0]))
    else $error("magnetization square does not match the sum");

endmodule

bind ising_metropolis_site_update imsu_checker u_imsu_checker (
  .clk                       (clk),
  .rst_n                     (rst_n),
  .start                     (start),
  .busy                      (busy),
  .out_valid                 (out_valid),
  .out_magnetization         (out_magnetization),
  .out_magnetization_squared (out_magnetization_squared)
);
